>>> hdl/ssd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package ssd_pkg;

  // Item and result formats.
  localparam int COORD_W   = 32;
  localparam int N_COORD   = 12;
  localparam int IN_DATA_W = COORD_W * N_COORD;
  localparam int OUT_W     = 33;
  localparam int OUT_DATA_W = 40;
  localparam int THR_W     = 32;

  // Internal arithmetic widths.
  localparam int DIFF_W     = COORD_W + 1;
  localparam int PROD_W     = 2 * DIFF_W;
  localparam int DOT_W      = PROD_W + 2;
  localparam int MUL_W      = DOT_W;
  localparam int WIDE_W     = 2 * MUL_W;
  localparam int PARAM_BITS = 32;
  localparam int PARAM_W    = PARAM_BITS + 1;
  localparam int DP_W       = 2 * DIFF_W + 1;
  localparam int RAD_W      = WIDE_W - 2 * PARAM_BITS;
  localparam int ROOT_W     = 35;
  localparam int SQ_W       = RAD_W + 2;

  typedef struct packed {
    logic [2:0][DIFF_W-1:0] u;
    logic [2:0][DIFF_W-1:0] v;
    logic [2:0][DIFF_W-1:0] w;
  } uvw_t;

  typedef struct packed {
    logic [DOT_W-1:0] a;
    logic [DOT_W-1:0] b;
    logic [DOT_W-1:0] c;
    logic [DOT_W-1:0] d;
    logic [DOT_W-1:0] e;
  } dots_t;

  typedef struct packed {
    logic [WIDE_W-1:0]     rem;
    logic [WIDE_W-1:0]     den;
    logic [PARAM_BITS-1:0] q;
    logic                  zero;
    logic                  one;
  } div_t;

  typedef struct packed {
    logic [RAD_W-1:0]  rad;
    logic [SQ_W-1:0]   sq;
    logic [ROOT_W-1:0] root;
  } sqrt_t;

endpackage

`default_nettype wire

>>> hdl/ssd_mul.sv
`timescale 1ns / 1ps
`default_nettype none

// Signed wide multiplier, four register stages: magnitudes, four half-width
// partial products, their sum, and the sign.
module ssd_mul import ssd_pkg::*; (
  input  logic                     clk,
  input  logic                     ce,
  input  logic signed [MUL_W-1:0]  a_i,
  input  logic signed [MUL_W-1:0]  b_i,
  output logic signed [WIDE_W-1:0] p_o
);

  localparam int HALF = MUL_W / 2;

  logic [MUL_W-1:0]    ma_r;
  logic [MUL_W-1:0]    mb_r;
  logic                neg1_r;
  logic                neg2_r;
  logic                neg3_r;
  logic [2*HALF-1:0]   ll_r;
  logic [2*HALF-1:0]   lh_r;
  logic [2*HALF-1:0]   hl_r;
  logic [2*HALF-1:0]   hh_r;
  logic [WIDE_W-1:0]   mag_r;
  logic signed [WIDE_W-1:0] p_r;

  always_ff @(posedge clk) begin
    if (ce) begin
      ma_r   <= a_i[MUL_W-1] ? MUL_W'(-a_i) : MUL_W'(a_i);
      mb_r   <= b_i[MUL_W-1] ? MUL_W'(-b_i) : MUL_W'(b_i);
      neg1_r <= a_i[MUL_W-1] ^ b_i[MUL_W-1];

      ll_r   <= ma_r[HALF-1:0] * mb_r[HALF-1:0];
      lh_r   <= ma_r[HALF-1:0] * mb_r[MUL_W-1:HALF];
      hl_r   <= ma_r[MUL_W-1:HALF] * mb_r[HALF-1:0];
      hh_r   <= ma_r[MUL_W-1:HALF] * mb_r[MUL_W-1:HALF];
      neg2_r <= neg1_r;

      mag_r  <= {hh_r, ll_r} + (WIDE_W'(lh_r) << HALF) + (WIDE_W'(hl_r) << HALF);
      neg3_r <= neg2_r;

      p_r    <= neg3_r ? -$signed(mag_r) : $signed(mag_r);
    end
  end

  assign p_o = p_r;

endmodule

`default_nettype wire

>>> hdl/segment_segment_distance.sv
`timescale 1ns / 1ps
`default_nettype none

// Shortest distance between two 3D segments, one pair per clock while the output is not stalled.
// Each input item on the in_ channel carries the endpoints a0, a1 of segment A
// and b0, b1 of segment B as signed Q16.16 coordinates. The matching result
// item on the out_ channel is the distance between the segments as unsigned
// Q17.16, truncated. Items come out in the order they went in.
// The datapath is a pipeline of 86 register stages. The first is loaded by the
// edge that accepts an item; the long stretches are the 32 restoring division
// steps for the two closest-point parameters and the 35 square-root steps, one
// bit per stage. A new item is accepted in every cycle in which the output is
// not stalled.
// The last stage is the output register. While it holds a result that the
// receiver does not take, the whole pipeline holds still and in_tready is low;
// nothing is dropped or repeated. A bubble-free stream runs at one item per
// cycle whenever out_tready stays high.
// small_threshold is written through cfg_we and cfg_wdata while the block is
// idle; the user must ensure this, the block does not. Reset (synchronous,
// rst_n low) empties the pipeline and sets the threshold to one.
module segment_segment_distance import ssd_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [THR_W-1:0]      cfg_wdata,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  // a0_x, a0_y, a0_z, a1_x, a1_y, a1_z, b0_x, b0_y, b0_z, b1_x, b1_y, b1_z
  // (32 bits each, from bit 0 up)
  input  logic [IN_DATA_W-1:0]  in_tdata,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // distance (bits 32:0), zeros above
  output logic [OUT_DATA_W-1:0] out_tdata
);

  // Stage positions in the pipeline.
  localparam int ST_PREP = 10;
  localparam int ST_SC   = ST_PREP + PARAM_BITS + 1;
  localparam int ST_RAD  = ST_SC + 7;
  localparam int NST     = ST_RAD + ROOT_W + 1;
  localparam int N_UVW   = ST_SC + 1;
  localparam int N_DOTS  = 7;
  localparam int N_DMUL  = 6;

  localparam logic [PARAM_W-1:0] PARAM_ONE = PARAM_W'(1) << PARAM_BITS;

  logic                 ce;
  logic [NST-1:0]       vld_r;
  logic [THR_W-1:0]     small_threshold_r;
  logic signed [WIDE_W-1:0] thr_w;

  // The whole pipeline advances unless a finished result is held back.
  assign ce         = !out_tvalid || out_tready;
  assign in_tready  = ce;
  assign out_tvalid = vld_r[NST-1];
  assign thr_w      = $signed(WIDE_W'(small_threshold_r));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r             <= '0;
      small_threshold_r <= THR_W'(1);
    end else begin
      if (ce) begin
        vld_r <= {vld_r[NST-2:0], in_tvalid};
      end
      if (cfg_we) begin
        small_threshold_r <= cfg_wdata;
      end
    end
  end

  // Stage 0: edge vectors u = a1 - a0, v = b1 - b0 and offset w = a0 - b0.
  uvw_t uvw_nxt;
  uvw_t uvw_r [N_UVW];

  always_comb begin
    logic [COORD_W-1:0] a0;
    logic [COORD_W-1:0] a1;
    logic [COORD_W-1:0] b0;
    logic [COORD_W-1:0] b1;
    uvw_nxt = '0;
    for (int i = 0; i < 3; i++) begin
      a0 = in_tdata[i*COORD_W +: COORD_W];
      a1 = in_tdata[(3+i)*COORD_W +: COORD_W];
      b0 = in_tdata[(6+i)*COORD_W +: COORD_W];
      b1 = in_tdata[(9+i)*COORD_W +: COORD_W];
      uvw_nxt.u[i] = $signed({a1[COORD_W-1], a1}) - $signed({a0[COORD_W-1], a0});
      uvw_nxt.v[i] = $signed({b1[COORD_W-1], b1}) - $signed({b0[COORD_W-1], b0});
      uvw_nxt.w[i] = $signed({a0[COORD_W-1], a0}) - $signed({b0[COORD_W-1], b0});
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      uvw_r[0] <= uvw_nxt;
      for (int k = 1; k < N_UVW; k++) begin
        uvw_r[k] <= uvw_r[k-1];
      end
    end
  end

  // Stage 1: the fifteen component products of the five dot products.
  logic signed [PROD_W-1:0] prod_nxt [15];
  logic signed [PROD_W-1:0] prod_r   [15];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      prod_nxt[i]    = $signed(uvw_r[0].u[i]) * $signed(uvw_r[0].u[i]);
      prod_nxt[3+i]  = $signed(uvw_r[0].u[i]) * $signed(uvw_r[0].v[i]);
      prod_nxt[6+i]  = $signed(uvw_r[0].v[i]) * $signed(uvw_r[0].v[i]);
      prod_nxt[9+i]  = $signed(uvw_r[0].u[i]) * $signed(uvw_r[0].w[i]);
      prod_nxt[12+i] = $signed(uvw_r[0].v[i]) * $signed(uvw_r[0].w[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      prod_r <= prod_nxt;
    end
  end

  // Stage 2: a = u.u, b = u.v, c = v.v, d = u.w, e = v.w.
  dots_t dots_nxt;
  dots_t dots_r [N_DOTS];

  always_comb begin
    dots_nxt.a = DOT_W'(prod_r[0])  + DOT_W'(prod_r[1])  + DOT_W'(prod_r[2]);
    dots_nxt.b = DOT_W'(prod_r[3])  + DOT_W'(prod_r[4])  + DOT_W'(prod_r[5]);
    dots_nxt.c = DOT_W'(prod_r[6])  + DOT_W'(prod_r[7])  + DOT_W'(prod_r[8]);
    dots_nxt.d = DOT_W'(prod_r[9])  + DOT_W'(prod_r[10]) + DOT_W'(prod_r[11]);
    dots_nxt.e = DOT_W'(prod_r[12]) + DOT_W'(prod_r[13]) + DOT_W'(prod_r[14]);
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      dots_r[0] <= dots_nxt;
      for (int k = 1; k < N_DOTS; k++) begin
        dots_r[k] <= dots_r[k-1];
      end
    end
  end

  // Stages 3 to 6: a*c, b*b, b*e, c*d, a*e and b*d in wide multipliers.
  logic signed [MUL_W-1:0]  dmul_a [N_DMUL];
  logic signed [MUL_W-1:0]  dmul_b [N_DMUL];
  logic signed [WIDE_W-1:0] dmul_p [N_DMUL];

  assign dmul_a[0] = $signed(dots_r[0].a);
  assign dmul_b[0] = $signed(dots_r[0].c);
  assign dmul_a[1] = $signed(dots_r[0].b);
  assign dmul_b[1] = $signed(dots_r[0].b);
  assign dmul_a[2] = $signed(dots_r[0].b);
  assign dmul_b[2] = $signed(dots_r[0].e);
  assign dmul_a[3] = $signed(dots_r[0].c);
  assign dmul_b[3] = $signed(dots_r[0].d);
  assign dmul_a[4] = $signed(dots_r[0].a);
  assign dmul_b[4] = $signed(dots_r[0].e);
  assign dmul_a[5] = $signed(dots_r[0].b);
  assign dmul_b[5] = $signed(dots_r[0].d);

  for (genvar g = 0; g < N_DMUL; g++) begin : g_dmul
    ssd_mul u_mul (
      .clk (clk),
      .ce  (ce),
      .a_i (dmul_a[g]),
      .b_i (dmul_b[g]),
      .p_o (dmul_p[g])
    );
  end

  // Stage 7: determinant and the unclamped numerators.
  logic signed [WIDE_W-1:0] det_r;
  logic signed [WIDE_W-1:0] sn0_r;
  logic signed [WIDE_W-1:0] tn0_r;

  always_ff @(posedge clk) begin
    if (ce) begin
      det_r <= dmul_p[0] - dmul_p[1];
      sn0_r <= dmul_p[2] - dmul_p[3];
      tn0_r <= dmul_p[4] - dmul_p[5];
    end
  end

  // Stage 8: parallel test and clamping of s to the ends of A.
  logic signed [WIDE_W-1:0] sn1_nxt, sd1_nxt, tn1_nxt, td1_nxt;
  logic signed [WIDE_W-1:0] sn1_r, sd1_r, tn1_r, td1_r;
  logic signed [DOT_W-1:0]  nd_r;
  logic signed [DOT_W-1:0]  ndb_r;
  logic signed [WIDE_W-1:0] b7_w, c7_w, e7_w;

  assign b7_w = WIDE_W'($signed(dots_r[5].b));
  assign c7_w = WIDE_W'($signed(dots_r[5].c));
  assign e7_w = WIDE_W'($signed(dots_r[5].e));

  always_comb begin
    sn1_nxt = sn0_r;
    sd1_nxt = det_r;
    tn1_nxt = tn0_r;
    td1_nxt = det_r;
    if (det_r < thr_w) begin
      // Nearly parallel or degenerate: fix s at the start of A.
      sn1_nxt = '0;
      sd1_nxt = WIDE_W'(1);
      tn1_nxt = e7_w;
      td1_nxt = c7_w;
    end else if (sn0_r < 0) begin
      sn1_nxt = '0;
      tn1_nxt = e7_w;
      td1_nxt = c7_w;
    end else if (sn0_r > det_r) begin
      sn1_nxt = det_r;
      tn1_nxt = e7_w + b7_w;
      td1_nxt = c7_w;
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      sn1_r <= sn1_nxt;
      sd1_r <= sd1_nxt;
      tn1_r <= tn1_nxt;
      td1_r <= td1_nxt;
      nd_r  <= -$signed(dots_r[5].d);
      ndb_r <= $signed(dots_r[5].b) - $signed(dots_r[5].d);
    end
  end

  // Stage 9: clamp t to the ends of B and recompute s where t was clamped.
  logic signed [WIDE_W-1:0] sn2_nxt, sd2_nxt, tn2_nxt;
  logic signed [WIDE_W-1:0] sn2_r, sd2_r, tn2_r, td2_r;
  logic signed [WIDE_W-1:0] sx_w;
  logic signed [WIDE_W-1:0] a8_w;
  logic                     tneg_w;
  logic                     tbig_w;

  assign tneg_w = tn1_r < 0;
  assign tbig_w = tn1_r > td1_r;
  assign sx_w   = tneg_w ? WIDE_W'(nd_r) : WIDE_W'(ndb_r);
  assign a8_w   = WIDE_W'($signed(dots_r[6].a));

  always_comb begin
    sn2_nxt = sn1_r;
    sd2_nxt = sd1_r;
    tn2_nxt = tn1_r;
    if (tneg_w || tbig_w) begin
      tn2_nxt = tneg_w ? '0 : td1_r;
      if (sx_w < 0) begin
        sn2_nxt = '0;
      end else if (sx_w > a8_w) begin
        sn2_nxt = sd1_r;
      end else begin
        sn2_nxt = sx_w;
        sd2_nxt = a8_w;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      sn2_r <= sn2_nxt;
      sd2_r <= sd2_nxt;
      tn2_r <= tn2_nxt;
      td2_r <= td1_r;
    end
  end

  // Stage 10 and the 32 stages after it: restoring fractional division
  // num/den for both parameters, one quotient bit per stage.
  function automatic div_t div_prep(input logic signed [WIDE_W-1:0] num,
                                    input logic signed [WIDE_W-1:0] den,
                                    input logic signed [WIDE_W-1:0] thr);
    div_t r;
    r.zero = (num <= 0) || (den <= 0) || (num < thr);
    r.one  = num >= den;
    r.rem  = num;
    r.den  = den;
    r.q    = '0;
    return r;
  endfunction

  function automatic div_t div_step(input div_t x);
    logic [WIDE_W:0] sh;
    logic [WIDE_W:0] dn;
    div_t            r;
    sh = {x.rem, 1'b0};
    dn = {1'b0, x.den};
    r  = x;
    if (sh >= dn) begin
      r.rem = WIDE_W'(sh - dn);
      r.q   = {x.q[PARAM_BITS-2:0], 1'b1};
    end else begin
      r.rem = sh[WIDE_W-1:0];
      r.q   = {x.q[PARAM_BITS-2:0], 1'b0};
    end
    return r;
  endfunction

  div_t divs_r [PARAM_BITS+1];
  div_t divt_r [PARAM_BITS+1];

  always_ff @(posedge clk) begin
    if (ce) begin
      divs_r[0] <= div_prep(sn2_r, sd2_r, thr_w);
      divt_r[0] <= div_prep(tn2_r, td2_r, thr_w);
      for (int k = 1; k <= PARAM_BITS; k++) begin
        divs_r[k] <= div_step(divs_r[k-1]);
        divt_r[k] <= div_step(divt_r[k-1]);
      end
    end
  end

  // Stage 43: parameters sc and tc in [0, 1] with 32 fraction bits.
  logic [PARAM_W-1:0] sc_r;
  logic [PARAM_W-1:0] tc_r;

  always_ff @(posedge clk) begin
    if (ce) begin
      sc_r <= divs_r[PARAM_BITS].zero ? '0 :
              divs_r[PARAM_BITS].one  ? PARAM_ONE : PARAM_W'(divs_r[PARAM_BITS].q);
      tc_r <= divt_r[PARAM_BITS].zero ? '0 :
              divt_r[PARAM_BITS].one  ? PARAM_ONE : PARAM_W'(divt_r[PARAM_BITS].q);
    end
  end

  // Stages 44 and 45: dP = w + sc*u - tc*v, exact with 32 extra fraction bits.
  logic signed [DP_W-1:0] wsh_r [3];
  logic signed [DP_W-1:0] usc_r [3];
  logic signed [DP_W-1:0] vtc_r [3];
  logic signed [DP_W-1:0] dp_r  [3];

  always_ff @(posedge clk) begin
    if (ce) begin
      for (int i = 0; i < 3; i++) begin
        wsh_r[i] <= DP_W'($signed(uvw_r[N_UVW-1].w[i])) <<< PARAM_BITS;
        usc_r[i] <= $signed(uvw_r[N_UVW-1].u[i]) * $signed({1'b0, sc_r});
        vtc_r[i] <= $signed(uvw_r[N_UVW-1].v[i]) * $signed({1'b0, tc_r});
        dp_r[i]  <= wsh_r[i] + usc_r[i] - vtc_r[i];
      end
    end
  end

  // Stages 46 to 49: squares of the three components.
  logic signed [MUL_W-1:0]  sqm_in [3];
  logic signed [WIDE_W-1:0] sqm_p  [3];

  for (genvar g = 0; g < 3; g++) begin : g_sqm
    assign sqm_in[g] = MUL_W'(dp_r[g]);
    ssd_mul u_mul (
      .clk (clk),
      .ce  (ce),
      .a_i (sqm_in[g]),
      .b_i (sqm_in[g]),
      .p_o (sqm_p[g])
    );
  end

  // Stage 50 onwards: squared length with the 64 extra fraction bits dropped,
  // then an integer square root, one result bit per stage from the top.
  logic [WIDE_W-1:0] sum_w;
  sqrt_t             sqr_r [ROOT_W+1];

  assign sum_w = WIDE_W'(sqm_p[0]) + WIDE_W'(sqm_p[1]) + WIDE_W'(sqm_p[2]);

  always_ff @(posedge clk) begin
    if (ce) begin
      sqr_r[0].rad  <= sum_w[WIDE_W-1:2*PARAM_BITS];
      sqr_r[0].sq   <= '0;
      sqr_r[0].root <= '0;
    end
  end

  for (genvar g = 0; g < ROOT_W; g++) begin : g_sqrt
    localparam int K = ROOT_W - 1 - g;
    logic [SQ_W-1:0] trial;

    // (root + 2^K)^2 = root^2 + root*2^(K+1) + 2^(2K), as root has no bit at K.
    assign trial = sqr_r[g].sq + (SQ_W'(sqr_r[g].root) << (K + 1)) + (SQ_W'(1) << (2 * K));

    always_ff @(posedge clk) begin
      if (ce) begin
        sqr_r[g+1].rad <= sqr_r[g].rad;
        if (trial <= SQ_W'(sqr_r[g].rad)) begin
          sqr_r[g+1].sq   <= trial;
          sqr_r[g+1].root <= sqr_r[g].root | (ROOT_W'(1) << K);
        end else begin
          sqr_r[g+1].sq   <= sqr_r[g].sq;
          sqr_r[g+1].root <= sqr_r[g].root;
        end
      end
    end
  end

  assign out_tdata = OUT_DATA_W'(sqr_r[ROOT_W].root[OUT_W-1:0]);

  // An accepted item is in the first stage in the next cycle.
  a_accept_enters: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> vld_r[0])
    else $error("accepted item did not enter the pipeline");

  // A held output freezes every stage's valid bit.
  a_stall_freezes: assert property (@(posedge clk) disable iff (!rst_n)
    !ce |=> $stable(vld_r))
    else $error("pipeline moved while the output was stalled");

  // The closest-point parameters never leave [0, 1].
  a_param_range: assert property (@(posedge clk) disable iff (!rst_n)
    vld_r[ST_SC] |-> (sc_r <= PARAM_ONE && tc_r <= PARAM_ONE))
    else $error("segment parameter out of range");

endmodule

`default_nettype wire

>>> dv/ssd_checker.sv
`timescale 1ns / 1ps

// Watches both streams of the segment distance block, works out the distance
// for every accepted item and compares it with the result items in order.
module ssd_checker import ssd_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [THR_W-1:0]      cfg_wdata,
  input  logic                  in_tvalid,
  input  logic                  in_tready,
  input  logic [IN_DATA_W-1:0]  in_tdata,
  input  logic                  out_tvalid,
  input  logic                  out_tready,
  input  logic [OUT_DATA_W-1:0] out_tdata,
  output int                    errors,
  output int                    pending
);

  typedef logic signed [191:0] wide_t;

  localparam wide_t UNIT = 192'sd4294967296;

  logic [THR_W-1:0] threshold;
  logic [OUT_W-1:0] dist_q[$];

  function automatic wide_t mag(wide_t x);
    return (x < 0) ? -x : x;
  endfunction

  // Parameter in Q1.32, truncated and clamped to the range [0, 1].
  function automatic wide_t seg_param(wide_t n, wide_t d, wide_t thr);
    wide_t q;
    q = 0;
    if (mag(n) < thr || d <= 0 || n <= 0) return 0;
    if (n >= d) return UNIT;
    for (int i = 0; i < 32; i++) begin
      n = n <<< 1;
      q = q <<< 1;
      if (n >= d) begin
        n = n - d;
        q = q + 1;
      end
    end
    return q;
  endfunction

  function automatic logic [OUT_W-1:0] closest_distance(logic [IN_DATA_W-1:0] pts,
                                                       logic [THR_W-1:0] t);
    wide_t u[3], v[3], w[3];
    wide_t a, b, c, d, e, det, sn, sd, tn, td, nd, x, thr, sc, tc, p, sum, cand;
    logic signed [31:0] k0, k1, m0, m1;
    logic [35:0] r;
    a = 0; b = 0; c = 0; d = 0; e = 0;
    for (int i = 0; i < 3; i++) begin
      k0 = pts[32*i +: 32];
      k1 = pts[32*(3+i) +: 32];
      m0 = pts[32*(6+i) +: 32];
      m1 = pts[32*(9+i) +: 32];
      u[i] = wide_t'(k1) - wide_t'(k0);
      v[i] = wide_t'(m1) - wide_t'(m0);
      w[i] = wide_t'(k0) - wide_t'(m0);
      a += u[i] * u[i];
      b += u[i] * v[i];
      c += v[i] * v[i];
      d += u[i] * w[i];
      e += v[i] * w[i];
    end
    det = a * c - b * b;
    thr = $signed({160'b0, t});
    sd = det;
    td = det;
    if (det < thr) begin
      // Parallel or degenerate: pin the A parameter and project onto B.
      sn = 0; sd = 1; tn = e; td = c;
    end else begin
      sn = b * e - c * d;
      tn = a * e - b * d;
      if (sn < 0) begin
        sn = 0; tn = e; td = c;
      end else if (sn > sd) begin
        sn = sd; tn = e + b; td = c;
      end
    end
    nd = -d;
    if (tn < 0 || tn > td) begin
      // B parameter clamped to one end, so redo the A parameter against it.
      if (tn < 0) begin
        tn = 0;
        x = nd;
      end else begin
        tn = td;
        x = nd + b;
      end
      if (x < 0) sn = 0;
      else if (x > a) sn = sd;
      else begin
        sn = x;
        sd = a;
      end
    end
    sc = seg_param(sn, sd, thr);
    tc = seg_param(tn, td, thr);
    sum = 0;
    for (int i = 0; i < 3; i++) begin
      p = w[i] * UNIT + u[i] * sc - v[i] * tc;
      sum += p * p;
    end
    r = 0;
    for (int k = 34; k >= 0; k--) begin
      cand = $signed({156'b0, r | (36'd1 << k)});
      if (((cand * cand) <<< 64) <= sum) r = r | (36'd1 << k);
    end
    return r[OUT_W-1:0];
  endfunction

  assign pending = dist_q.size();

  always @(posedge clk) begin
    if (!rst_n) begin
      threshold <= 1;
      errors    <= 0;
      dist_q.delete();
    end else begin
      if (cfg_we) threshold <= cfg_wdata;
      if (in_tvalid && in_tready) dist_q.push_back(closest_distance(in_tdata, threshold));
      if (out_tvalid && out_tready) begin
        if (dist_q.size() == 0) begin
          $error("distance: no item waiting, actual %0d", out_tdata[OUT_W-1:0]);
          errors <= errors + 1;
        end else if (dist_q[0] !== out_tdata[OUT_W-1:0]) begin
          $error("distance: expected %0d, actual %0d", dist_q[0], out_tdata[OUT_W-1:0]);
          errors <= errors + 1;
          void'(dist_q.pop_front());
        end else begin
          void'(dist_q.pop_front());
        end
      end
    end
  end

endmodule

>>> dv/segment_segment_distance_tb.sv
`timescale 1ns / 1ps

// Stimulus and verdict for the segment distance block. Checking is done
// entirely by ssd_checker, which sits beside the block on the same wires.
module segment_segment_distance_tb;
  import ssd_pkg::*;

  localparam int LATENCY    = 100;
  localparam int CYCLE_STOP = 400000;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  cfg_we = 1'b0;
  logic [THR_W-1:0]      cfg_wdata = '0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata = '0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;
  int                    errors;
  int                    pending;
  int                    cycles = 0;

  // Control of the receiver: quiet switches idling off, long_hold asks for
  // one long stall.
  logic quiet = 1'b0;
  logic long_hold = 1'b0;

  always #6 clk = ~clk;

  segment_segment_distance dut (
    .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata)
  );

  ssd_checker chk (
    .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .errors(errors), .pending(pending)
  );

  // Watchdog: the slowest correct run is far below this.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_STOP) begin
      $display("segment_segment_distance_tb NOT OK");
      $finish;
    end
  end

  // Receiver: random stall bursts, one long stall on request, none when quiet.
  initial begin
    forever begin
      if (long_hold) begin
        out_tready <= 1'b0;
        repeat (300) @(posedge clk);
        long_hold = 1'b0;
      end else if (!quiet && $urandom_range(0, 6) == 0) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(1, 13)) @(posedge clk);
      end else begin
        out_tready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  // Offer one item; the valid line is only lowered when a gap is taken, so it
  // never gets two assignments in one step.
  task automatic send_pair(input int pt[12]);
    logic [IN_DATA_W-1:0] data;
    for (int i = 0; i < 12; i++) data[32*i +: 32] = pt[i];
    if (!quiet && $urandom_range(0, 5) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= data;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  // Let the block drain completely, then change the threshold. The first edge
  // lets the checker record the last accepted item before the count is read.
  task automatic set_threshold(input logic [THR_W-1:0] value);
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (LATENCY) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  function automatic int coord_in(int span);
    return $urandom_range(0, 2 * span) - span;
  endfunction

  // A random segment pair. Four kinds in ten have structure (parallel, touching,
  // degenerate, nearly parallel) so that every branch of the closest-point
  // method is taken; two are raw bit patterns, the rest random in a span.
  task automatic random_pair(output int pt[12]);
    int kind, span, scale;
    kind = $urandom_range(0, 9);
    span = (kind == 8) ? 32'h3fffffff : (1 << $urandom_range(4, 22));
    for (int i = 0; i < 12; i++) pt[i] = (kind <= 1) ? $urandom : coord_in(span);
    case (kind)
      5: begin
        // Parallel, possibly reversed and scaled.
        scale = $urandom_range(0, 6) - 3;
        for (int i = 0; i < 3; i++) pt[9+i] = pt[6+i] + scale * (pt[3+i] - pt[i]);
      end
      6: begin
        // One or both segments shrunk to a point.
        for (int i = 0; i < 3; i++) begin
          pt[3+i] = pt[i];
          if ($urandom_range(0, 1)) pt[9+i] = pt[6+i];
        end
      end
      7: begin
        // B starts where A ends.
        for (int i = 0; i < 3; i++) pt[6+i] = pt[3+i];
      end
      9: begin
        // Nearly parallel.
        for (int i = 0; i < 3; i++) pt[9+i] = pt[6+i] + pt[3+i] - pt[i] + coord_in(2);
      end
      default: ;
    endcase
  endtask

  initial begin
    int pt[12];
    int unit_x;
    logic [THR_W-1:0] thr_seq[5];

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part, run with the threshold at its reset value of one.
    unit_x = 32'h10000;
    pt = '{default: 0};
    send_pair(pt);
    // Opposite corners of the coordinate cube, the same diagonal once each way.
    pt = '{32'h80000000, 32'h80000000, 32'h80000000, 32'h7fffffff, 32'h7fffffff,
           32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 32'h80000000,
           32'h80000000, 32'h80000000};
    send_pair(pt);
    // Two points at opposite corners: the largest distance.
    pt = '{32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000,
           32'h80000000, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff,
           32'h7fffffff, 32'h7fffffff};
    send_pair(pt);
    // Parallel segments one unit apart, then the same with B reversed.
    pt = '{0, 0, 0, 10*unit_x, 0, 0, 0, unit_x, 0, 10*unit_x, unit_x, 0};
    send_pair(pt);
    pt = '{0, 0, 0, 10*unit_x, 0, 0, 10*unit_x, unit_x, 0, 0, unit_x, 0};
    send_pair(pt);
    // Perpendicular, crossing over each other at height two.
    pt = '{-unit_x, 0, 0, unit_x, 0, 0, 0, -unit_x, 2*unit_x, 0, unit_x, 2*unit_x};
    send_pair(pt);
    // Perpendicular with both closest points beyond the ends.
    pt = '{0, 0, 0, unit_x, 0, 0, 3*unit_x, 2*unit_x, unit_x, 3*unit_x, 5*unit_x,
           unit_x};
    send_pair(pt);
    // A point against a segment, and a segment against a point.
    pt = '{unit_x, unit_x, unit_x, unit_x, unit_x, unit_x, 0, 0, 0, 4*unit_x, 0, 0};
    send_pair(pt);
    pt = '{0, 0, 0, 4*unit_x, 0, 0, unit_x, -unit_x, 3, unit_x, -unit_x, 3};
    send_pair(pt);
    // Collinear and overlapping: distance zero.
    pt = '{0, 0, 0, 5*unit_x, 0, 0, 2*unit_x, 0, 0, 9*unit_x, 0, 0};
    send_pair(pt);
    // Segments touching at one end.
    pt = '{1, 2, 3, 7, 5, 9, 7, 5, 9, -4, 11, 6};
    send_pair(pt);
    // Single LSB coordinates, where the near-zero numerator rule matters.
    pt = '{0, 0, 0, 1, 0, 0, 0, 1, 1, 1, 1, 0};
    send_pair(pt);

    // Random part in phases, each under another threshold, with the extremes.
    thr_seq = '{32'd1, 32'd0, 32'hffffffff, $urandom, 32'd1 << $urandom_range(0, 31)};
    for (int ph = 0; ph < 5; ph++) begin
      // The sender pauses here until every result has come back.
      if (ph != 0) set_threshold(thr_seq[ph]);
      for (int j = 0; j < 180; j++) begin
        if (ph == 2 && j == 20) long_hold = 1'b1;
        if (ph == 4 && j == 100) quiet = 1'b1;
        random_pair(pt);
        send_pair(pt);
      end
    end
    in_tvalid <= 1'b0;
    @(posedge clk);

    while (pending != 0) @(posedge clk);
    repeat (LATENCY) @(posedge clk);
    if (errors == 0) begin
      $display("segment_segment_distance_tb OK");
    end else begin
      $display("segment_segment_distance_tb NOT OK");
    end
    $finish;
  end

endmodule

>>> filelist.f
hdl/ssd_pkg.sv
hdl/ssd_mul.sv
hdl/segment_segment_distance.sv
dv/ssd_checker.sv
dv/segment_segment_distance_tb.sv
